### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define LCDSEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define LCDSEQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lcdseq_pkg.sv
package lcdseq_pkg;

  localparam logic [3:0] STEP_IDLE      = 4'd0;
  localparam logic [3:0] STEP_PWR_FIRST = 4'd1;
  localparam logic [3:0] STEP_PWR_LAST  = 4'd9;
  localparam logic [3:0] STEP_PAUSE     = 4'd10;
  localparam logic [3:0] STEP_HOME      = 4'd11;
  localparam logic [3:0] STEP_TEXT      = 4'd12;

  localparam logic [6:0] WAIT_RESET = 7'd20;
  localparam logic [6:0] WAIT_PAUSE = 7'd100;
  localparam logic [6:0] WAIT_HOME  = 7'd3;
  localparam logic [6:0] WAIT_KICK  = 7'd1;
  localparam logic [6:0] WAIT_NONE  = 7'd0;

  localparam logic [5:0] LEN_HOME = 6'd2;
  localparam logic [5:0] LEN_TEXT = 6'd34;

  localparam logic [3:0] NIB_HOME_HI = 4'h8;
  localparam logic [3:0] NIB_HOME_LO = 4'h0;

  localparam logic [4:0] BYTE_LINE2 = 5'd8;
  localparam logic [4:0] BYTE_VOL0  = 5'd9;
  localparam logic [7:0] LINE2_ADDR = 8'd192;

  localparam logic [9:0] VALUE_MAX = 10'd999;
  localparam logic [9:0] HUND_STEP = 10'd100;
  localparam logic [9:0] TENS_STEP = 10'd10;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_B     = "B";
  localparam logic [7:0] CH_P     = "P";
  localparam logic [7:0] CH_M     = "M";
  localparam logic [7:0] CH_V     = "V";
  localparam logic [7:0] CH_O     = "o";
  localparam logic [7:0] CH_L     = "l";
  localparam logic [7:0] CH_COLON = ":";
  localparam logic [7:0] CH_U     = "u";
  localparam logic [7:0] CH_T     = "t";
  localparam logic [7:0] CH_E     = "e";
  localparam logic [7:0] CH_PCT   = "%";

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } bcd_digits_t;

  function automatic logic [3:0] pwr_nib(logic [3:0] step, logic second);
    logic [7:0] pair;
    unique case (step)
      4'd1, 4'd2, 4'd3: pair = 8'h30;
      4'd4:             pair = 8'h20;
      4'd5:             pair = 8'h28;
      4'd6:             pair = 8'h0E;
      4'd7:             pair = 8'h01;
      4'd8:             pair = 8'h06;
      4'd9:             pair = 8'h80;
      default:          pair = 8'h00;
    endcase
    return second ? pair[3:0] : pair[7:4];
  endfunction

  function automatic logic [5:0] pwr_len(logic [3:0] step);
    return (step <= 4'd4) ? 6'd1 : 6'd2;
  endfunction

  function automatic logic [6:0] pwr_wait(logic [3:0] step);
    logic [6:0] w;
    unique case (step)
      4'd1:    w = 7'd5;
      4'd7:    w = 7'd2;
      default: w = 7'd1;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d);
    return CH_ZERO + {4'd0, d};
  endfunction

  function automatic logic [7:0] num_char(logic [1:0] pos, bcd_digits_t d);
    logic [7:0] c;
    case (pos)
      2'd0:    c = (d.hund == 4'd0) ? CH_SPACE : digit_char(d.hund);
      2'd1:    c = (d.hund == 4'd0 && d.tens == 4'd0) ? CH_SPACE : digit_char(d.tens);
      default: c = digit_char(d.units);
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tempo_char(logic [2:0] i, bcd_digits_t d);
    logic [7:0] c;
    case (i)
      3'd0, 3'd1, 3'd2: c = num_char(i[1:0], d);
      3'd4:             c = CH_B;
      3'd5:             c = CH_P;
      3'd6:             c = CH_M;
      default:          c = CH_SPACE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] vol_char(logic [2:0] i, logic mute, bcd_digits_t d);
    logic [7:0] c;
    case (i)
      3'd0:    c = CH_V;
      3'd1:    c = CH_O;
      3'd2:    c = CH_L;
      3'd3:    c = CH_COLON;
      3'd4:    c = mute ? CH_M : num_char(2'd0, d);
      3'd5:    c = mute ? CH_U : num_char(2'd1, d);
      3'd6:    c = mute ? CH_T : num_char(2'd2, d);
      default: c = mute ? CH_E : CH_PCT;
    endcase
    return c;
  endfunction

  // Returns the register select bit above the byte of one refresh transfer.
  function automatic logic [8:0] text_byte(logic [4:0] idx, logic valid, logic mute,
                                           bcd_digits_t td, bcd_digits_t vd);
    logic [4:0] vidx;
    logic [7:0] b;
    logic       rs;
    vidx = idx - BYTE_VOL0;
    rs   = 1'b1;
    if (idx == BYTE_LINE2) begin
      rs = 1'b0;
      b  = LINE2_ADDR;
    end else if (!valid) begin
      b = 8'd0;
    end else if (idx < BYTE_LINE2) begin
      b = tempo_char(idx[2:0], td);
    end else begin
      b = vol_char(vidx[2:0], mute, vd);
    end
    return {rs, b};
  endfunction

endpackage

### rtl/lcdseq_if.sv
interface lcdseq_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [9:0] volume;
  logic [9:0] tempo;

  modport source (output valid, output command, output volume, output tempo, input ready);
  modport sink (input valid, input command, input volume, input tempo, output ready);
endinterface

interface lcdseq_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, output reg_select, output nibble, output last, input ready);
  modport sink (input valid, input reg_select, input nibble, input last, output ready);
endinterface

### rtl/lcdseq_bcd.sv
`include "assert_macros.svh"

module lcdseq_bcd (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [9:0]                value,
  output logic                      done,
  output lcdseq_pkg::bcd_digits_t   digits
);
  import lcdseq_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_HUND, B_TENS} bstate_t;

  bstate_t    state_r;
  logic [9:0] rem_r;
  logic [3:0] hund_r;
  logic [3:0] tens_r;
  logic       done_r;
  logic [9:0] sub;
  logic [9:0] diff;
  logic       borrow;

  // One compare and subtract unit serves both digit positions.
  assign sub              = (state_r == B_HUND) ? HUND_STEP : TENS_STEP;
  assign {borrow, diff}   = {1'b0, rem_r} - {1'b0, sub};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (start) begin
            rem_r   <= (value > VALUE_MAX) ? VALUE_MAX : value;
            hund_r  <= 4'd0;
            tens_r  <= 4'd0;
            state_r <= B_HUND;
          end
        end
        B_HUND: begin
          if (!borrow) begin
            rem_r  <= diff;
            hund_r <= hund_r + 4'd1;
          end else begin
            state_r <= B_TENS;
          end
        end
        B_TENS: begin
          if (!borrow) begin
            rem_r  <= diff;
            tens_r <= tens_r + 4'd1;
          end else begin
            done_r  <= 1'b1;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign digits = '{hund: hund_r, tens: tens_r, units: rem_r[3:0]};

  `LCDSEQ_ASSERT(a_tens_below_hundred, (state_r == B_TENS) |-> (rem_r < HUND_STEP), "tens phase remainder not below 100")
  `LCDSEQ_ASSERT(a_units_digit, done_r |-> (rem_r < TENS_STEP), "units digit out of range")
  `LCDSEQ_ASSERT(a_done_one_cycle, done_r |=> !done_r, "conversion done held longer than one cycle")

endmodule

### rtl/char_lcd_4bit_init_refresh_sequencer.sv
// Character LCD sequencer for a 4-bit bus. Each input item is a millisecond tick or a refresh
// request; each result item is one nibble with its register select bit, and the last nibble a
// tick causes carries last. A tick with nothing due, or one that runs the pause step, emits
// nothing and leaves the sequencer ready for the next item. A tick that runs any other step
// emits 1, 2 or 34 nibbles through the output register, which hands over one nibble per cycle
// while the sink is ready. A refresh request formats tempo and volume with one shared compare
// and subtract unit, one step per cycle, and causes no result. No item is taken while a step
// is emitting or a conversion runs.
`include "assert_macros.svh"

module char_lcd_4bit_init_refresh_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  lcdseq_in_if.sink       in_ch,
  lcdseq_out_if.source    out_ch
);
  import lcdseq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EMIT, S_CONV_T, S_CONV_V} state_t;

  state_t      state_r;
  logic [3:0]  step_r;
  logic [3:0]  emit_step_r;
  logic [7:0]  elapsed_r;
  logic [6:0]  wait_r;
  logic [5:0]  cnt_r;
  logic [5:0]  len_r;
  logic [9:0]  tempo_r;
  logic [9:0]  volume_r;
  bcd_digits_t tdig_r;
  bcd_digits_t vdig_r;
  logic        mute_r;
  logic        txt_valid_r;
  logic        bcd_start_r;
  logic        out_valid_r;
  logic        out_rs_r;
  logic [3:0]  out_nib_r;
  logic        out_last_r;

  logic        in_fire;
  logic        slot_free;
  logic [7:0]  elapsed_inc;
  logic        due;
  logic        cur_rs;
  logic [3:0]  cur_nib;
  logic [8:0]  cur_byte;
  logic        cur_last;
  logic [9:0]  bcd_value;
  logic        bcd_done;
  bcd_digits_t bcd_digits;

  lcdseq_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start_r),
    .value  (bcd_value),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  assign bcd_value   = (state_r == S_CONV_T) ? tempo_r : volume_r;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign elapsed_inc = (elapsed_r == 8'hFF) ? elapsed_r : elapsed_r + 8'd1;
  assign due         = (step_r != STEP_IDLE) && (step_r <= STEP_TEXT) &&
                       (elapsed_inc > {1'b0, wait_r});
  assign cur_byte    = text_byte(cnt_r[5:1], txt_valid_r, mute_r, tdig_r, vdig_r);
  assign cur_last    = (cnt_r == len_r - 6'd1);

  always_comb begin
    cur_rs  = 1'b0;
    cur_nib = 4'd0;
    case (emit_step_r) inside
      [STEP_PWR_FIRST:STEP_PWR_LAST]: cur_nib = pwr_nib(emit_step_r, cnt_r[0]);
      STEP_HOME: cur_nib = cnt_r[0] ? NIB_HOME_LO : NIB_HOME_HI;
      STEP_TEXT: begin
        cur_rs  = cur_byte[8];
        cur_nib = cnt_r[0] ? cur_byte[3:0] : cur_byte[7:4];
      end
      default: cur_nib = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_PWR_FIRST;
      emit_step_r <= STEP_IDLE;
      elapsed_r   <= 8'd0;
      wait_r      <= WAIT_RESET;
      cnt_r       <= 6'd0;
      len_r       <= 6'd0;
      txt_valid_r <= 1'b0;
      bcd_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bcd_start_r <= 1'b0;
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.command) begin
            tempo_r     <= in_ch.tempo;
            volume_r    <= in_ch.volume;
            bcd_start_r <= 1'b1;
            state_r     <= S_CONV_T;
            if (step_r == STEP_IDLE) begin
              step_r <= STEP_HOME;
              wait_r <= WAIT_KICK;
            end
          end else if (in_fire) begin
            elapsed_r <= elapsed_inc;
            if (due) begin
              case (step_r) inside
                [STEP_PWR_FIRST:STEP_PWR_LAST]: begin
                  wait_r      <= pwr_wait(step_r);
                  elapsed_r   <= 8'd0;
                  step_r      <= step_r + 4'd1;
                  emit_step_r <= step_r;
                  len_r       <= pwr_len(step_r);
                  cnt_r       <= 6'd0;
                  state_r     <= S_EMIT;
                end
                STEP_PAUSE: begin
                  wait_r <= WAIT_PAUSE;
                  step_r <= STEP_HOME;
                end
                STEP_HOME: begin
                  wait_r      <= WAIT_HOME;
                  elapsed_r   <= 8'd0;
                  step_r      <= STEP_TEXT;
                  emit_step_r <= STEP_HOME;
                  len_r       <= LEN_HOME;
                  cnt_r       <= 6'd0;
                  state_r     <= S_EMIT;
                end
                STEP_TEXT: begin
                  wait_r      <= WAIT_NONE;
                  step_r      <= STEP_IDLE;
                  emit_step_r <= STEP_TEXT;
                  len_r       <= LEN_TEXT;
                  cnt_r       <= 6'd0;
                  state_r     <= S_EMIT;
                end
                default: ;
              endcase
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_rs_r    <= cur_rs;
            out_nib_r   <= cur_nib;
            out_last_r  <= cur_last;
            cnt_r       <= cnt_r + 6'd1;
            if (cur_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        S_CONV_T: begin
          if (bcd_done) begin
            tdig_r      <= bcd_digits;
            bcd_start_r <= 1'b1;
            state_r     <= S_CONV_V;
          end
        end
        S_CONV_V: begin
          if (bcd_done) begin
            vdig_r      <= bcd_digits;
            mute_r      <= (volume_r == 10'd0);
            txt_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_select = out_rs_r;
  assign out_ch.nibble     = out_nib_r;
  assign out_ch.last       = out_last_r;

  `LCDSEQ_ASSERT(a_cnt_in_range, (state_r == S_EMIT) |-> (cnt_r < len_r), "nibble count past step length")
  `LCDSEQ_ASSERT(a_step_reachable, step_r <= STEP_TEXT, "step code beyond text transfer")
  `LCDSEQ_ASSERT(a_pwr_clears_wait, (in_fire && !in_ch.command && due && step_r <= STEP_PWR_LAST) |=> (elapsed_r == 8'd0), "power-up step did not restart the wait")

endmodule
